FILE: rtl/tga_pkg.sv
`default_nettype none

package tga_pkg;

	// counter width for column and row, sizes taken modulo 2^DIM_BITS
	localparam int DIM_BITS = 16;
	localparam int COORD_W  = 16;
	localparam int IDX_W    = 2;
	localparam int CFG_W    = 16;

	typedef logic [DIM_BITS-1:0] dim_t;

	// pixel formats selected by depth_mode (the unused code decodes as bgra)
	typedef enum logic [1:0] {
		DEPTH_ARGB1555 = 2'd0,
		DEPTH_BGR888   = 2'd1,
		DEPTH_BGRA8888 = 2'd2
	} depth_mode_t;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DEPTH_MODE   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2,
		REG_TOP_ORIGIN   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  depth_mode;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        top_origin;
	} cfg_regs_t;

	// byte gatherer status toward the pipeline control
	typedef struct packed {
		logic        done;
		logic [31:0] argb;
	} gather_res_t;

	// pixel position toward the output register
	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic               last;
	} coord_res_t;

endpackage

`default_nettype wire

FILE: rtl/tga_byte_if.sv
`default_nettype none

interface tga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/tga_pixel_if.sv
`default_nettype none

interface tga_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_argb;
	logic [15:0] column;
	logic [15:0] row;
	logic        last_pixel;

	modport source (output valid, output pixel_argb, output column, output row,
		output last_pixel, input ready);
	modport sink (input valid, input pixel_argb, input column, input row,
		input last_pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/tga_cfg_if.sv
`default_nettype none

interface tga_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: rtl/tga_truecolor_pixel_unpacker.sv
// path: the final byte of a pixel is held in the input register, the pixel word in the output register
// throughput: one byte per cycle unless a finished pixel waits behind a full output register
// a pixel word leaves every 2, 3 or 4 bytes by depth mode
// reset: arst_n clears pipeline valids, byte phase and counters; registers go to
// 32-bit bgra, 1 x 1 image, bottom origin
`default_nettype none

module tga_truecolor_pixel_unpacker (
	input  wire         clk,
	input  wire         arst_n,
	tga_cfg_if.sink     cfg,
	tga_byte_if.sink    bytes,
	tga_pixel_if.source pixels
);
	import tga_pkg::*;

	cfg_regs_t   regs;
	gather_res_t gres;
	coord_res_t  cres;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fire;
	logic        out_free;

	logic        valid_s2;
	logic [31:0] argb_s2;
	logic [15:0] column_s2;
	logic [15:0] row_s2;
	logic        last_s2;

	tga_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tga_byte_gather u_gather (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (byte_s1),
		.depth_mode (regs.depth_mode),
		.res        (gres)
	);

	tga_pixel_coord u_coord (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire && gres.done),
		.regs   (regs),
		.res    (cres)
	);

	// stage 1 retires when no pixel is made or the output slot opens
	assign out_free    = !valid_s2 || pixels.ready;
	assign fire        = valid_s1 && (!gres.done || out_free);
	assign bytes.ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && gres.done) begin
			valid_s2 <= 1'b1;
		end else if (pixels.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire && gres.done) begin
			argb_s2   <= gres.argb;
			column_s2 <= cres.column;
			row_s2    <= cres.row;
			last_s2   <= cres.last;
		end
	end

	assign pixels.valid      = valid_s2;
	assign pixels.pixel_argb = argb_s2;
	assign pixels.column     = column_s2;
	assign pixels.row        = row_s2;
	assign pixels.last_pixel = last_s2;

	// a finished pixel always lands in the output register
	a_pixel_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && gres.done) |=> valid_s2)
		else $error("finished pixel not presented");

	// counters restart after the final pixel
	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && gres.done && cres.last) |=> (cres.column == '0))
		else $error("column counter did not wrap after final pixel");

	// a full output slot with a finishing byte behind it stalls the input
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && gres.done && valid_s2 && !pixels.ready) |-> !bytes.ready)
		else $error("input taken while finished pixel blocked");

	// no pixel may be lost when the output slot is occupied
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !pixels.ready) |=> (valid_s2 && $stable(argb_s2)))
		else $error("pending pixel overwritten");

endmodule

`default_nettype wire

FILE: rtl/tga_cfg_regs.sv
`default_nettype none

module tga_cfg_regs (
	input  wire                 clk,
	input  wire                 arst_n,
	tga_cfg_if.sink             cfg,
	output tga_pkg::cfg_regs_t  regs
);
	import tga_pkg::*;

	cfg_regs_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.depth_mode   <= DEPTH_BGRA8888;
			regs_q.image_width  <= 16'd1;
			regs_q.image_height <= 16'd1;
			regs_q.top_origin   <= 1'b0;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_DEPTH_MODE:   regs_q.depth_mode   <= cfg.wdata[1:0];
				REG_IMAGE_WIDTH:  regs_q.image_width  <= cfg.wdata;
				REG_IMAGE_HEIGHT: regs_q.image_height <= cfg.wdata;
				REG_TOP_ORIGIN:   regs_q.top_origin   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

FILE: rtl/tga_byte_gather.sv
`default_nettype none

module tga_byte_gather (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   fire,
	input  wire [7:0]             data_byte,
	input  wire [1:0]             depth_mode,
	output tga_pkg::gather_res_t  res
);
	import tga_pkg::*;

	logic [1:0]  phase_q;
	logic [23:0] held_q;
	logic [1:0]  need_m1;
	logic        done;
	logic [15:0] d16;
	logic [31:0] argb;
	logic [23:0] held_next;

	// index of the final byte of a pixel
	always_comb begin
		case (depth_mode_t'(depth_mode))
			DEPTH_ARGB1555: need_m1 = 2'd1;
			DEPTH_BGR888:   need_m1 = 2'd2;
			default:        need_m1 = 2'd3;
		endcase
	end

	assign done = (phase_q >= need_m1);

	// merge the last byte and convert to argb32
	always_comb begin
		d16 = held_q[15:0] | {data_byte, 8'h00};
		case (depth_mode_t'(depth_mode))
			DEPTH_ARGB1555: argb = {{8{d16[15]}}, d16[14:10], 3'b000,
				d16[9:5], 3'b000, d16[4:0], 3'b000};
			DEPTH_BGR888:   argb = {8'hFF, held_q[23:16] | data_byte, held_q[15:0]};
			default:        argb = {data_byte, held_q};
		endcase
	end

	// place a non-final byte at its lane
	always_comb begin
		held_next = held_q;
		case (phase_q)
			2'd0:    held_next[7:0]   = held_q[7:0]   | data_byte;
			2'd1:    held_next[15:8]  = held_q[15:8]  | data_byte;
			2'd2:    held_next[23:16] = held_q[23:16] | data_byte;
			default: ;
		endcase
	end

	// phase counter and held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			held_q  <= 24'd0;
		end else if (fire) begin
			if (done) begin
				phase_q <= 2'd0;
				held_q  <= 24'd0;
			end else begin
				phase_q <= phase_q + 2'd1;
				held_q  <= held_next;
			end
		end
	end

	assign res.done = done;
	assign res.argb = argb;

endmodule

`default_nettype wire

FILE: rtl/tga_pixel_coord.sv
`default_nettype none

module tga_pixel_coord (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  tga_pkg::cfg_regs_t   regs,
	output tga_pkg::coord_res_t  res
);
	import tga_pkg::*;

	dim_t col_q;
	dim_t row_q;
	dim_t w_last;
	dim_t h_last;
	dim_t y;
	logic end_col;
	logic end_row;

	// last index of each axis, zero size means full range
	assign w_last  = regs.image_width[DIM_BITS-1:0] - dim_t'(1);
	assign h_last  = regs.image_height[DIM_BITS-1:0] - dim_t'(1);
	assign end_col = (col_q == w_last);
	assign end_row = (row_q == h_last);

	// bottom-up storage flips the row
	assign y = regs.top_origin ? row_q : (h_last - row_q);

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? dim_t'(0) : row_q + dim_t'(1);
			end else begin
				col_q <= col_q + dim_t'(1);
			end
		end
	end

	assign res.column = COORD_W'(col_q);
	assign res.row    = COORD_W'(y);
	assign res.last   = end_col && end_row;

endmodule

`default_nettype wire
